// ===== rtl/ranked_multiset_with_global_offset_macros.svh =====
// Assertion macros for the ranked multiset block (use clk and arst_n of the including module).
`ifndef RANKED_MULTISET_WITH_GLOBAL_OFFSET_MACROS_SVH
`define RANKED_MULTISET_WITH_GLOBAL_OFFSET_MACROS_SVH

// condition holds at every edge out of reset
`define RMGO_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define RMGO_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMGO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rmgo_pkg.sv =====
// Shared constants, codes and types of the ranked multiset block.
package rmgo_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int AMT_W    = 20;
	localparam int OP_W     = 2;
	localparam int KEPT_W   = 11;
	localparam int DEP_W    = 32;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 80;
	localparam int M_USER_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_ADD    = 2'd1,
		OP_SUB    = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	// command broadcast to every cell
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_ADD,
		CMD_SUB,
		CMD_LOAD_VAL,
		CMD_LOAD_KEEP,
		CMD_SHIFT
	} cell_cmd_e;

	typedef struct packed {
		cell_cmd_e          kind;
		logic [AMT_W-1:0]   operand;
		logic [CNT_W-1:0]   count;
		logic [AMT_W-1:0]   thr;
	} cell_cmd_t;

	typedef struct packed {
		logic               busy;
		logic [CNT_W-1:0]   count;
	} stat_t;

endpackage

// ===== rtl/ranked_multiset_with_global_offset.sv =====
// Top level of the ranked multiset: cell chain, sequencer, threshold register, ports.
//
//  channel   dir   handshake           payload
//  cfg       in    cfg_we              cfg_wdata = min_threshold
//  s_*       in    s_tvalid/s_tready   s_tuser = op, s_tdata = amount
//  m_*       out   m_tvalid/m_tready   m_tuser = flags, m_tdata = answer/counts
//
// Steps per word: insert and add are applied when the word is accepted; find of rank k
// loads the taps, shifts the tap chain toward cell 0, then registers the answer;
// subtract applies the offset, flags the entries to keep, then scans the keep flags
// through cell 0. A find outside 1..count answers without using the chain.
// One word is in work at a time; the next is taken no earlier than the cycle in
// which the previous result is accepted, so a stalled result holds the input off.
// Reset clears count, departure total, threshold and control; the cell values
// are not reset, since only entries below the count are ever read.
module ranked_multiset_with_global_offset (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rmgo_pkg::AMT_W-1:0]          cfg_wdata,    // min_threshold
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rmgo_pkg::S_DATA_W-1:0]       s_tdata,      // [19:0] amount, [23:20] zero
	input  logic [rmgo_pkg::OP_W-1:0]           s_tuser,      // [1:0] op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] answer, [42:32] kept_count, [74:43] departed_count, [79:75] zero
	output logic [rmgo_pkg::M_DATA_W-1:0]       m_tdata,
	output logic [rmgo_pkg::M_USER_W-1:0]       m_tuser       // [0] answer_valid, [1] insert_dropped
);

	`include "ranked_multiset_with_global_offset_macros.svh"

	logic [rmgo_pkg::AMT_W-1:0]         thr_q;
	rmgo_pkg::cell_cmd_t                cmd;
	rmgo_pkg::stat_t                    stat;

	// chain wiring: values and insert flags move right, taps move left
	logic signed [rmgo_pkg::VAL_W-1:0]  val [rmgo_pkg::CAPACITY];
	logic                               lt  [rmgo_pkg::CAPACITY];
	logic [rmgo_pkg::VAL_W-1:0]         tap [rmgo_pkg::CAPACITY+1];

	logic                               answer_valid;
	logic [rmgo_pkg::VAL_W-1:0]         answer;
	logic [rmgo_pkg::KEPT_W-1:0]        kept_count;
	logic [rmgo_pkg::DEP_W-1:0]         departed_count;
	logic                               insert_dropped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	rmgo_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_valid        (s_tvalid),
		.s_ready        (s_tready),
		.op             (rmgo_pkg::op_t'(s_tuser)),
		.amount         (s_tdata[rmgo_pkg::AMT_W-1:0]),
		.thr            (thr_q),
		.tap0           (tap[0]),
		.m_ready        (m_tready),
		.m_valid        (m_tvalid),
		.answer_valid   (answer_valid),
		.answer         (answer),
		.kept_count     (kept_count),
		.departed_count (departed_count),
		.insert_dropped (insert_dropped),
		.cmd            (cmd),
		.stat           (stat)
	);

	assign tap[rmgo_pkg::CAPACITY] = '0;

	for (genvar i = 0; i < rmgo_pkg::CAPACITY; i++) begin : g_cell
		logic signed [rmgo_pkg::VAL_W-1:0] left_val;
		logic                              left_lt;

		if (i == 0) begin : g_head
			assign left_val = '0;
			assign left_lt  = 1'b0;
		end else begin : g_body
			assign left_val = val[i-1];
			assign left_lt  = lt[i-1];
		end

		rmgo_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.index     (rmgo_pkg::IDX_W'(i)),
			.left_val  (left_val),
			.left_lt   (left_lt),
			.right_tap (tap[i+1]),
			.val       (val[i]),
			.lt        (lt[i]),
			.tap       (tap[i])
		);
	end

	assign m_tdata = {
		{(rmgo_pkg::M_DATA_W - rmgo_pkg::VAL_W - rmgo_pkg::KEPT_W - rmgo_pkg::DEP_W){1'b0}},
		departed_count, kept_count, answer
	};
	assign m_tuser = {insert_dropped, answer_valid};

	// count never passes capacity
	`RMGO_ASSERT_ALWAYS(a_count_cap, stat.count <= rmgo_pkg::CNT_W'(rmgo_pkg::CAPACITY), "count over capacity")
	// an accepted word either answers at once or starts a multi-cycle op
	`RMGO_ASSERT_NEXT(a_accept_progress, s_tvalid && s_tready, m_tvalid || stat.busy, "accepted word lost")
	// a dropped insert is only reported while the store is full
	`RMGO_ASSERT_IMPL(a_drop_full, m_tvalid && m_tuser[1], stat.count == rmgo_pkg::CNT_W'(rmgo_pkg::CAPACITY), "drop while not full")
	// no stale word is offered while the chain is working
	`RMGO_ASSERT_IMPL(a_busy_quiet, stat.busy, !m_tvalid, "output valid during chain work")

endmodule

// ===== rtl/rmgo_cell.sv =====
// One cell of the sorted chain: a stored value and a tap register that shifts toward cell 0.
module rmgo_cell (
	input  logic                                clk,
	input  rmgo_pkg::cell_cmd_t                 cmd,
	input  logic [rmgo_pkg::IDX_W-1:0]          index,
	input  logic signed [rmgo_pkg::VAL_W-1:0]   left_val,
	input  logic                                left_lt,
	input  logic [rmgo_pkg::VAL_W-1:0]          right_tap,
	output logic signed [rmgo_pkg::VAL_W-1:0]   val,
	output logic                                lt,
	output logic [rmgo_pkg::VAL_W-1:0]          tap
);

	logic signed [rmgo_pkg::VAL_W-1:0] val_q;
	logic [rmgo_pkg::VAL_W-1:0]        tap_q;
	logic signed [rmgo_pkg::VAL_W:0]   ext;
	logic signed [rmgo_pkg::VAL_W:0]   sum;
	logic signed [rmgo_pkg::VAL_W-1:0] sat;
	logic signed [rmgo_pkg::VAL_W-1:0] ins_v;
	logic signed [rmgo_pkg::VAL_W-1:0] thr_v;
	logic                              in_use;
	logic                              keep;

	assign ext   = $signed((rmgo_pkg::VAL_W + 1)'(cmd.operand));
	assign ins_v = $signed(rmgo_pkg::VAL_W'(cmd.operand));
	assign thr_v = $signed(rmgo_pkg::VAL_W'(cmd.thr));

	always_comb begin
		if (cmd.kind == rmgo_pkg::CMD_SUB) begin
			sum = {val_q[rmgo_pkg::VAL_W-1], val_q} - ext;
		end else begin
			sum = {val_q[rmgo_pkg::VAL_W-1], val_q} + ext;
		end
		// clamp when the two top bits disagree
		if (sum[rmgo_pkg::VAL_W] != sum[rmgo_pkg::VAL_W-1]) begin
			sat = sum[rmgo_pkg::VAL_W] ? {1'b1, {(rmgo_pkg::VAL_W-1){1'b0}}}
				: {1'b0, {(rmgo_pkg::VAL_W-1){1'b1}}};
		end else begin
			sat = sum[rmgo_pkg::VAL_W-1:0];
		end
	end

	// chain holds values largest first; entries at or past count are unused
	assign in_use = rmgo_pkg::CNT_W'(index) < cmd.count;
	assign lt     = !in_use || (val_q < ins_v);
	assign keep   = val_q >= thr_v;

	always_ff @(posedge clk) begin
		case (cmd.kind)
			rmgo_pkg::CMD_INSERT: begin
				if (lt) begin
					val_q <= left_lt ? left_val : ins_v;
				end
			end
			rmgo_pkg::CMD_ADD,
			rmgo_pkg::CMD_SUB: begin
				val_q <= sat;
			end
			rmgo_pkg::CMD_LOAD_VAL: begin
				tap_q <= val_q;
			end
			rmgo_pkg::CMD_LOAD_KEEP: begin
				tap_q <= rmgo_pkg::VAL_W'(keep);
			end
			rmgo_pkg::CMD_SHIFT: begin
				tap_q <= right_tap;
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;
	assign tap = tap_q;

endmodule

// ===== rtl/rmgo_ctrl.sv =====
// Sequencer: count, departure total, cell commands and the output word register.
module rmgo_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_valid,
	output logic                            s_ready,
	input  rmgo_pkg::op_t                   op,
	input  logic [rmgo_pkg::AMT_W-1:0]      amount,
	input  logic [rmgo_pkg::AMT_W-1:0]      thr,
	input  logic [rmgo_pkg::VAL_W-1:0]      tap0,
	input  logic                            m_ready,
	output logic                            m_valid,
	output logic                            answer_valid,
	output logic [rmgo_pkg::VAL_W-1:0]      answer,
	output logic [rmgo_pkg::KEPT_W-1:0]     kept_count,
	output logic [rmgo_pkg::DEP_W-1:0]      departed_count,
	output logic                            insert_dropped,
	output rmgo_pkg::cell_cmd_t             cmd,
	output rmgo_pkg::stat_t                 stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_KEEP,
		ST_SCAN
	} state_t;

	state_t                         st_q;
	logic [rmgo_pkg::CNT_W-1:0]     count_q;
	logic [rmgo_pkg::CNT_W-1:0]     steps_q;
	logic [rmgo_pkg::DEP_W-1:0]     dep_q;
	logic                           m_valid_q;
	logic                           ans_valid_q;
	logic [rmgo_pkg::VAL_W-1:0]     answer_q;
	logic                           dropped_q;

	logic                           out_free;
	logic                           accept;
	logic                           k_ok;
	logic                           ins_ok;
	logic                           full;
	logic                           scan_go;
	logic [rmgo_pkg::CNT_W-1:0]     gone;
	logic [rmgo_pkg::DEP_W:0]       dep_sum;
	logic [rmgo_pkg::DEP_W-1:0]     dep_next;

	assign out_free = !m_valid_q || m_ready;
	assign s_ready  = (st_q == ST_IDLE) && out_free;
	assign accept   = s_valid && s_ready;
	assign k_ok     = (amount != '0) && (32'(amount) <= 32'(count_q));
	assign ins_ok   = amount >= thr;
	assign full     = count_q >= rmgo_pkg::CNT_W'(rmgo_pkg::CAPACITY);
	assign scan_go  = (steps_q < count_q) && tap0[0];
	assign gone     = count_q - steps_q;
	assign dep_sum  = {1'b0, dep_q} + (rmgo_pkg::DEP_W + 1)'(gone);
	assign dep_next = dep_sum[rmgo_pkg::DEP_W] ? '1 : dep_sum[rmgo_pkg::DEP_W-1:0];

	always_comb begin
		cmd.kind    = rmgo_pkg::CMD_HOLD;
		cmd.operand = amount;
		cmd.count   = count_q;
		cmd.thr     = thr;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						rmgo_pkg::OP_INSERT: begin
							if (ins_ok && !full) begin
								cmd.kind = rmgo_pkg::CMD_INSERT;
							end
						end
						rmgo_pkg::OP_ADD: cmd.kind = rmgo_pkg::CMD_ADD;
						rmgo_pkg::OP_SUB: cmd.kind = rmgo_pkg::CMD_SUB;
						rmgo_pkg::OP_FIND: begin
							if (k_ok) begin
								cmd.kind = rmgo_pkg::CMD_LOAD_VAL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FIND: begin
				if (steps_q != '0) begin
					cmd.kind = rmgo_pkg::CMD_SHIFT;
				end
			end
			ST_KEEP: cmd.kind = rmgo_pkg::CMD_LOAD_KEEP;
			ST_SCAN: begin
				if (scan_go) begin
					cmd.kind = rmgo_pkg::CMD_SHIFT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			dep_q       <= '0;
			m_valid_q   <= 1'b0;
			ans_valid_q <= 1'b0;
			answer_q    <= '0;
			dropped_q   <= 1'b0;
		end else begin
			if (m_valid_q && m_ready) begin
				m_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						ans_valid_q <= 1'b0;
						answer_q    <= '0;
						dropped_q   <= 1'b0;
						case (op)
							rmgo_pkg::OP_INSERT: begin
								m_valid_q <= 1'b1;
								if (ins_ok && full) begin
									dropped_q <= 1'b1;
								end
								if (ins_ok && !full) begin
									count_q <= count_q + 1'b1;
								end
							end
							rmgo_pkg::OP_ADD: m_valid_q <= 1'b1;
							rmgo_pkg::OP_SUB: st_q <= ST_KEEP;
							rmgo_pkg::OP_FIND: begin
								if (k_ok) begin
									steps_q <= rmgo_pkg::CNT_W'(amount - 1'b1);
									st_q    <= ST_FIND;
								end else begin
									m_valid_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FIND: begin
					if (steps_q != '0) begin
						steps_q <= steps_q - 1'b1;
					end else if (out_free) begin
						answer_q    <= tap0;
						ans_valid_q <= 1'b1;
						m_valid_q   <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				ST_KEEP: begin
					steps_q <= '0;
					st_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					// steps_q counts survivors, a prefix of the chain
					if (scan_go) begin
						steps_q <= steps_q + 1'b1;
					end else if (out_free) begin
						count_q   <= steps_q;
						dep_q     <= dep_next;
						m_valid_q <= 1'b1;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_valid        = m_valid_q;
	assign answer_valid   = ans_valid_q;
	assign answer         = answer_q;
	assign kept_count     = rmgo_pkg::KEPT_W'(count_q);
	assign departed_count = dep_q;
	assign insert_dropped = dropped_q;
	assign stat.busy      = st_q != ST_IDLE;
	assign stat.count     = count_q;

endmodule
